### rtl/core/ress_pkg.sv
// ----------------------------------------------------------------------------
// ress_pkg
// Shared types and constants for the rectangle edge snap search.
// ----------------------------------------------------------------------------
package ress_pkg;

	localparam int COORD_W = 34;           // edge positions, 1/512 units
	localparam int DIFF_W  = 35;           // signed edge difference
	localparam int THR_W   = 33;           // snap threshold
	localparam int ADDR_W  = 4;            // APB byte address
	localparam int DATA_W  = 64;           // APB data

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(4096);

	// Register index, decoded from paddr[3] (8-byte register slots)
	localparam logic REG_SNAP_THRESHOLD = 1'b0;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic        [COORD_W-1:0] mag_t;
	typedef coord_t      [2:0]         trio_t;  // start, center, end

	// Per-axis control from the top level
	typedef struct packed {
		logic load;    // mode-0 word: capture moving edges, restart search
		logic update;  // mode-1 word: compare candidate edges
	} axis_ctl_t;

	// Best match of one axis after the current word
	typedef struct packed {
		logic   have;
		diff_t  offset;
		coord_t position;
	} axis_res_t;

endpackage

### rtl/core/rect_edge_snap_search.sv
// ----------------------------------------------------------------------------
// rect_edge_snap_search
// Snap-to-guide search of a moving rectangle against candidate rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per rectangle. A word with
//   mode=0 loads the moving rectangle, samples snap_threshold and restarts
//   the search and the span box; mode=1 words bring candidates and widen the
//   span box. A word with last=1 produces one result word.
//   Output channel (out_valid/out_ready): found flags, signed offsets,
//   guide positions and spans, all in 1/512 units.
//   Path: a last word goes through the input register, then the result
//   register, which drives the output channel.
//   Throughput: one word per cycle unless stalled (below). The running best
//   of each axis is updated by a combinational nine-pair compare tree, so
//   the next word uses the state left by the previous one without a bubble.
//   Stall: while the result register is full and out_ready is low, a last
//   word in the input register waits and in_ready drops; non-last words
//   keep flowing.
//   Reset: all search state, spans and out_valid clear to zero;
//   snap_threshold returns to 4096. Write the threshold over APB (64-bit
//   register at byte address 0) only while the block is idle.
// ----------------------------------------------------------------------------
module rect_edge_snap_search (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ress_pkg::ADDR_W-1:0]   paddr,
	input  logic [ress_pkg::DATA_W-1:0]   pwdata,
	output logic [ress_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// input words
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic signed [31:0]            rect_x,
	input  logic signed [31:0]            rect_y,
	input  logic [30:0]                   rect_width,
	input  logic [30:0]                   rect_height,
	input  logic                          last,
	// result words
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found_x,
	output logic signed [33:0]            offset_x,
	output logic signed [33:0]            guide_x_position,
	output logic signed [33:0]            span_top,
	output logic signed [33:0]            span_bottom,
	output logic                          found_y,
	output logic signed [33:0]            offset_y,
	output logic signed [33:0]            guide_y_position,
	output logic signed [33:0]            span_left,
	output logic signed [33:0]            span_right
);
	import ress_pkg::*;

	// ---------------------------------------------------------------- config
	logic [THR_W-1:0] threshold_q;
	logic             reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[3] == REG_SNAP_THRESHOLD) && (paddr[2:0] == 3'd0);
	assign prdata  = reg_hit ? DATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[3] == REG_SNAP_THRESHOLD) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	// ------------------------------------------------------- edge expansion
	// start = 2*pos, center = 2*pos + len, end = 2*pos + 2*len
	trio_t  ex_in, ey_in;
	coord_t x2, y2;

	always_comb begin
		x2       = coord_t'($signed({rect_x[31], rect_x, 1'b0}));
		y2       = coord_t'($signed({rect_y[31], rect_y, 1'b0}));
		ex_in[0] = x2;
		ex_in[1] = x2 + coord_t'({3'b000, rect_width});
		ex_in[2] = x2 + coord_t'({2'b00, rect_width, 1'b0});
		ey_in[0] = y2;
		ey_in[1] = y2 + coord_t'({3'b000, rect_height});
		ey_in[2] = y2 + coord_t'({2'b00, rect_height, 1'b0});
	end

	// -------------------------------------------------------- input register
	logic  valid_s1, mode_s1, last_s1;
	trio_t ex_s1, ey_s1;
	logic  advance;

	// a last word may only move on when the result register has room
	assign advance  = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			last_s1 <= last;
			ex_s1   <= ex_in;
			ey_s1   <= ey_in;
		end
	end

	// ----------------------------------------------------------- axis search
	axis_ctl_t ctl;
	axis_res_t res_x, res_y;

	assign ctl.load   = advance && !mode_s1;
	assign ctl.update = advance && mode_s1;

	ress_axis u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.threshold (threshold_q),
		.cand      (ex_s1),
		.res_nxt   (res_x)
	);

	ress_axis u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.threshold (threshold_q),
		.cand      (ey_s1),
		.res_nxt   (res_y)
	);

	// --------------------------------------------------------------- span box
	coord_t top_q, bottom_q, left_q, right_q;
	coord_t top_nxt, bottom_nxt, left_nxt, right_nxt;

	always_comb begin
		top_nxt    = top_q;
		bottom_nxt = bottom_q;
		left_nxt   = left_q;
		right_nxt  = right_q;
		if (ctl.load) begin
			top_nxt    = ey_s1[0];
			bottom_nxt = ey_s1[2];
			left_nxt   = ex_s1[0];
			right_nxt  = ex_s1[2];
		end else if (ctl.update) begin
			if ($signed(ey_s1[0]) < $signed(top_q))    top_nxt    = ey_s1[0];
			if ($signed(ey_s1[2]) > $signed(bottom_q)) bottom_nxt = ey_s1[2];
			if ($signed(ex_s1[0]) < $signed(left_q))   left_nxt   = ex_s1[0];
			if ($signed(ex_s1[2]) > $signed(right_q))  right_nxt  = ex_s1[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bottom_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
		end else begin
			top_q    <= top_nxt;
			bottom_q <= bottom_nxt;
			left_q   <= left_nxt;
			right_q  <= right_nxt;
		end
	end

	// ------------------------------------------------------- result register
	logic emit;

	assign emit = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// offsets and positions stay zero until a snap is found, so no masking
	always_ff @(posedge clk) begin
		if (emit) begin
			found_x          <= res_x.have;
			offset_x         <= res_x.offset[COORD_W-1:0];
			guide_x_position <= res_x.position;
			found_y          <= res_y.have;
			offset_y         <= res_y.offset[COORD_W-1:0];
			guide_y_position <= res_y.position;
			span_top         <= top_nxt;
			span_bottom      <= bottom_nxt;
			span_left        <= left_nxt;
			span_right       <= right_nxt;
		end
	end

endmodule

### rtl/core/ress_axis.sv
// ----------------------------------------------------------------------------
// ress_axis
// Nine-pair edge compare and running best match for one axis.
// ----------------------------------------------------------------------------
module ress_axis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ress_pkg::axis_ctl_t           ctl,
	input  logic [ress_pkg::THR_W-1:0]    threshold,
	input  ress_pkg::trio_t               cand,
	output ress_pkg::axis_res_t           res_nxt
);
	import ress_pkg::*;

	trio_t  moving_q;
	mag_t   best_abs_q;
	diff_t  best_off_q;
	coord_t best_pos_q;
	logic   have_q;

	mag_t   abs_v [9];
	diff_t  off_v [9];
	coord_t pos_v [9];

	logic [3:0] l1 [4];
	logic [3:0] l2 [2];
	logic [3:0] l3;
	logic [3:0] win;

	mag_t   best_abs_nxt;
	logic   hit;

	// keep the left one on a tie: first pair in scan order wins
	function automatic logic [3:0] pick(input logic [3:0] ia, input mag_t a,
	                                    input logic [3:0] ib, input mag_t b);
		return (b < a) ? ib : ia;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				off_v[i*3+j] = DIFF_W'($signed(cand[j])) - DIFF_W'($signed(moving_q[i]));
				pos_v[i*3+j] = cand[j];
				abs_v[i*3+j] = off_v[i*3+j][DIFF_W-1]
					? COORD_W'(-off_v[i*3+j]) : COORD_W'(off_v[i*3+j]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			l1[k] = pick(4'(2*k), abs_v[2*k], 4'(2*k+1), abs_v[2*k+1]);
		end
		l2[0] = pick(l1[0], abs_v[l1[0]], l1[1], abs_v[l1[1]]);
		l2[1] = pick(l1[2], abs_v[l1[2]], l1[3], abs_v[l1[3]]);
		l3    = pick(l2[0], abs_v[l2[0]], l2[1], abs_v[l2[1]]);
		win   = pick(l3, abs_v[l3], 4'd8, abs_v[8]);
		hit   = abs_v[win] < best_abs_q;
	end

	always_comb begin
		res_nxt.have     = have_q;
		res_nxt.offset   = best_off_q;
		res_nxt.position = best_pos_q;
		best_abs_nxt     = best_abs_q;
		if (ctl.load) begin
			res_nxt.have     = 1'b0;
			res_nxt.offset   = '0;
			res_nxt.position = '0;
			best_abs_nxt     = COORD_W'(threshold);
		end else if (ctl.update && hit) begin
			res_nxt.have     = 1'b1;
			res_nxt.offset   = off_v[win];
			res_nxt.position = pos_v[win];
			best_abs_nxt     = abs_v[win];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q   <= '0;
			best_abs_q <= '0;
			best_off_q <= '0;
			best_pos_q <= '0;
			have_q     <= 1'b0;
		end else begin
			if (ctl.load) begin
				moving_q <= cand;
			end
			best_abs_q <= best_abs_nxt;
			best_off_q <= res_nxt.offset;
			best_pos_q <= res_nxt.position;
			have_q     <= res_nxt.have;
		end
	end

endmodule

### verif/rect_edge_snap_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_edge_snap_search_tb
// Self-checking bench for the rectangle edge snap search.
// A short table of hand-picked words runs first. Some rows carry a result
// typed in by hand. Random searches follow over several snap thresholds:
// zero, maximum, reset value and random values. Every result word is checked
// field by field against its typed row or an in-bench tracker of the running
// best match and span box. Both channels idle at random; the result side holds
// off once for a long stretch so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module rect_edge_snap_search_tb;
	import ress_pkg::*;

	// word kinds
	localparam logic MODE_MOVING    = 1'b0;
	localparam logic MODE_CANDIDATE = 1'b1;

	// register map: 8-byte slots, index in paddr[3]
	localparam logic [ADDR_W-1:0] THR_ADDR      = {REG_SNAP_THRESHOLD, 3'b000};
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {~REG_SNAP_THRESHOLD, 3'b000};
	localparam logic [THR_W-1:0]  THR_MAX       = '1;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;

	localparam longint POS_MIN = -64'sd2147483648;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint LEN_MAX = 64'sd2147483647;

	localparam int ITEM_TARGET  = 1150;
	localparam int PHASE_WORDS  = 95;
	localparam int HOLD_AT      = 500;     // words taken before the long hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 6;       // two-stage pipe plus margin
	localparam int MAX_REPORTS  = 10;
	localparam longint TIMEOUT_NS = 64'd5_000_000;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        w;
		logic [30:0]        h;
		logic               last;
	} rect_word_t;

	typedef struct packed {
		logic   found_x;
		coord_t offset_x;
		coord_t guide_x;
		coord_t span_top;
		coord_t span_bottom;
		logic   found_y;
		coord_t offset_y;
		coord_t guide_y;
		coord_t span_left;
		coord_t span_right;
	} snap_result_t;

	typedef struct {
		rect_word_t   word;
		bit           typed;
		snap_result_t want;
	} script_row_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [ADDR_W-1:0]   paddr       = '0;
	logic [DATA_W-1:0]   pwdata      = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                mode        = 1'b0;
	logic signed [31:0]  rect_x      = '0;
	logic signed [31:0]  rect_y      = '0;
	logic [30:0]         rect_width  = '0;
	logic [30:0]         rect_height = '0;
	logic                last        = 1'b0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic                found_x;
	logic signed [33:0]  offset_x;
	logic signed [33:0]  guide_x_position;
	logic signed [33:0]  span_top;
	logic signed [33:0]  span_bottom;
	logic                found_y;
	logic signed [33:0]  offset_y;
	logic signed [33:0]  guide_y_position;
	logic signed [33:0]  span_left;
	logic signed [33:0]  span_right;

	rect_edge_snap_search u_dut (.*);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Snap tracker: own copy of the search state, indexed by axis
	// (x: left/right edges, y: top/bottom edges)
	// ------------------------------------------------------------------------
	logic [THR_W-1:0] snap_limit = THR_RESET;
	longint move_edge [2][3];     // start, center, end in 1/512 units
	longint best_mag  [2];
	longint best_off  [2];
	longint best_pos  [2];
	bit     best_have [2];
	longint box_lo    [2];        // left, top
	longint box_hi    [2];        // right, bottom

	snap_result_t awaited_snaps [$];
	script_row_t  script [$];
	int  snap_errors = 0;
	int  words_taken = 0;
	bit  src_idle    = 1'b1;
	bit  snk_idle    = 1'b1;
	bit  hold_results = 1'b0;

	// Advance the tracker by one accepted word; return 1 when it emits.
	function automatic bit track_snap(input rect_word_t w, output snap_result_t r);
		longint org [2];
		longint len [2];
		longint cand;
		longint diff;
		longint mag;
		org[AX_X] = longint'($signed(w.x));
		org[AX_Y] = longint'($signed(w.y));
		len[AX_X] = longint'(w.w);
		len[AX_Y] = longint'(w.h);
		for (int ax = 0; ax < 2; ax++) begin
			if (w.mode == MODE_MOVING) begin
				for (int k = 0; k < 3; k++)
					move_edge[ax][k] = 2 * org[ax] + k * len[ax];
				// best starts at the limit so a snap must come in strictly below it
				best_mag[ax]  = longint'(snap_limit);
				best_off[ax]  = 0;
				best_pos[ax]  = 0;
				best_have[ax] = 1'b0;
				box_lo[ax]    = 2 * org[ax];
				box_hi[ax]    = 2 * org[ax] + 2 * len[ax];
			end else begin
				// moving edge outer, candidate edge inner; first strict win holds
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						cand = 2 * org[ax] + j * len[ax];
						diff = cand - move_edge[ax][i];
						mag  = (diff < 0) ? -diff : diff;
						if (mag < best_mag[ax]) begin
							best_mag[ax]  = mag;
							best_off[ax]  = diff;
							best_pos[ax]  = cand;
							best_have[ax] = 1'b1;
						end
					end
				end
				if (2 * org[ax] < box_lo[ax])
					box_lo[ax] = 2 * org[ax];
				if (2 * org[ax] + 2 * len[ax] > box_hi[ax])
					box_hi[ax] = 2 * org[ax] + 2 * len[ax];
			end
		end
		r.found_x     = best_have[AX_X];
		r.offset_x    = best_have[AX_X] ? coord_t'(best_off[AX_X]) : '0;
		r.guide_x     = best_have[AX_X] ? coord_t'(best_pos[AX_X]) : '0;
		r.span_top    = coord_t'(box_lo[AX_Y]);
		r.span_bottom = coord_t'(box_hi[AX_Y]);
		r.found_y     = best_have[AX_Y];
		r.offset_y    = best_have[AX_Y] ? coord_t'(best_off[AX_Y]) : '0;
		r.guide_y     = best_have[AX_Y] ? coord_t'(best_pos[AX_Y]) : '0;
		r.span_left   = coord_t'(box_lo[AX_X]);
		r.span_right  = coord_t'(box_hi[AX_X]);
		return w.last;
	endfunction

	function automatic rect_word_t word(input logic m, input longint x, input longint y,
			input longint w, input longint h, input logic l);
		rect_word_t r;
		r.mode = m;
		r.x    = 32'(x);
		r.y    = 32'(y);
		r.w    = 31'(w);
		r.h    = 31'(h);
		r.last = l;
		return r;
	endfunction

	function automatic snap_result_t outcome(input logic fx, input longint ox, input longint gx,
			input longint top, input longint bot, input logic fy, input longint oy,
			input longint gy, input longint lft, input longint rgt);
		snap_result_t r;
		r.found_x     = fx;
		r.offset_x    = coord_t'(ox);
		r.guide_x     = coord_t'(gx);
		r.span_top    = coord_t'(top);
		r.span_bottom = coord_t'(bot);
		r.found_y     = fy;
		r.offset_y    = coord_t'(oy);
		r.guide_y     = coord_t'(gy);
		r.span_left   = coord_t'(lft);
		r.span_right  = coord_t'(rgt);
		return r;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input rect_word_t w, input bit typed,
			input snap_result_t want);
		script.insert(script.size(), '{w, typed, want});
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] seen);
		if (seen !== want) begin
			snap_errors++;
			if (snap_errors <= MAX_REPORTS)
				$display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, seen);
		end
	endtask

	// ------------------------------------------------------------------------
	// Input side: draw a gap, offer the word, hold it until taken
	// ------------------------------------------------------------------------
	task automatic send_word(input rect_word_t w, input bit typed, input snap_result_t want);
		int gap;
		snap_result_t r;
		// no gaps during the hold-off so the block fills up
		gap = (src_idle && !hold_results) ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode        <= w.mode;
		rect_x      <= w.x;
		rect_y      <= w.y;
		rect_width  <= w.w;
		rect_height <= w.h;
		last        <= w.last;
		in_valid    <= 1'b1;
		// look at ready mid-cycle; the word moves at the following edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		words_taken++;
		if (track_snap(w, r))
			awaited_snaps.insert(awaited_snaps.size(), typed ? want : r);
	endtask

	// ------------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------------
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		flag_mismatch("prdata", want, prdata);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drop valid, wait out every pending result, then let the pipe empty
	// (a trailing non-last word can still sit in the input register).
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_snaps.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Random searches
	// ------------------------------------------------------------------------
	function automatic longint rand_len();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return longint'($urandom_range(0, 4096));
			6, 7:             return longint'($urandom_range(0, 1 << 20));
			default:          return longint'($urandom & 32'h7FFF_FFFF);
		endcase
	endfunction

	function automatic longint rand_pos();
		if ($urandom_range(0, 9) < 3)
			return longint'($signed($urandom));
		return longint'($urandom_range(0, 1 << 21)) - (64'sd1 <<< 20);
	endfunction

	// Land near the moving edge, sometimes exactly on it.
	function automatic longint jitter(input longint base, input longint reach);
		if ($urandom_range(0, 7) == 0)
			return base;
		return base + longint'($urandom_range(0, 32'(2 * reach))) - reach;
	endfunction

	// One search: a moving word, then candidates near it. Occasionally skip
	// the moving word so candidates continue the previous search, slip in a
	// noise word, or cut a result mid-search.
	task automatic run_search();
		longint mx;
		longint my;
		longint mw;
		longint mh;
		longint reach;
		int     n;
		bit     fin;
		mx = rand_pos();
		my = rand_pos();
		mw = rand_len();
		mh = rand_len();
		n  = $urandom_range(0, 8);
		// offsets in Q23.8 are half of those in 1/512 units
		reach = longint'(snap_limit) / 2 + 8;
		if (reach > (64'sd1 <<< 30))
			reach = 64'sd1 <<< 30;
		if ($urandom_range(0, 9) == 0)
			send_word(word($urandom_range(0, 1) ? MODE_CANDIDATE : MODE_MOVING,
				rand_pos(), rand_pos(), rand_len(), rand_len(),
				1'($urandom_range(0, 1))), 1'b0, '0);
		if ($urandom_range(0, 7) != 0)
			send_word(word(MODE_MOVING, mx, my, mw, mh, n == 0), 1'b0, '0);
		for (int k = 1; k <= n; k++) begin
			fin = (k == n) || ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 4) == 0)
				send_word(word(MODE_CANDIDATE, rand_pos(), rand_pos(), rand_len(),
					rand_len(), fin), 1'b0, '0);
			else
				send_word(word(MODE_CANDIDATE, jitter(mx, reach), jitter(my, reach),
					$urandom_range(0, 1) ? mw : rand_len(),
					$urandom_range(0, 1) ? mh : rand_len(), fin), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [THR_W-1:0] thr;
		int               phase_end;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold comes out of reset at its default
		apb_read_check(THR_ADDR, DATA_W'(THR_RESET));

		// Directed table, threshold at its reset value.
		// Candidate before any search: compared against the all-zero state,
		// never snaps, box grows out of the zero box.
		add_row(word(MODE_CANDIDATE, 100, -50, 10, 20, 1'b1), 1'b1,
			outcome(0, 0, 0, -100, 0, 0, 0, 0, 0, 220));
		// moving word with last: result at once, spans of the moving rect alone
		add_row(word(MODE_MOVING, 0, 0, 1000, 500, 1'b1), 1'b1,
			outcome(0, 0, 0, 0, 1000, 0, 0, 0, 0, 2000));
		// coordinate and size extremes
		add_row(word(MODE_MOVING, POS_MIN, POS_MAX, LEN_MAX, LEN_MAX, 1'b1), 1'b1,
			outcome(0, 0, 0, 2 * POS_MAX, 2 * POS_MAX + 2 * LEN_MAX, 0, 0, 0,
				2 * POS_MIN, 2 * POS_MIN + 2 * LEN_MAX));
		add_row(word(MODE_MOVING, POS_MAX, POS_MIN, 0, 0, 1'b1), 1'b1,
			outcome(0, 0, 0, 2 * POS_MIN, 2 * POS_MIN, 0, 0, 0, 2 * POS_MAX, 2 * POS_MAX));
		// a short search: near hit, tie with opposite sign, zero offset,
		// then a candidate after the result
		add_row(word(MODE_MOVING, 1000, 1000, 400, 200, 1'b0), 1'b0, '0);
		add_row(word(MODE_CANDIDATE, 1010, 3000, 100, 100, 1'b0), 1'b0, '0);
		add_row(word(MODE_CANDIDATE, 990, 1100, 0, 0, 1'b1), 1'b0, '0);
		add_row(word(MODE_CANDIDATE, 999, 1099, 1, 1, 1'b1), 1'b0, '0);
		// offset equal to the threshold misses, one step inside snaps
		add_row(word(MODE_MOVING, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(word(MODE_CANDIDATE, 2048, -2048, 0, 0, 1'b1), 1'b1,
			outcome(0, 0, 0, -4096, 0, 0, 0, 0, 0, 4096));
		add_row(word(MODE_CANDIDATE, 2047, -2047, 0, 0, 1'b1), 1'b1,
			outcome(1, 4094, 4094, -4096, 0, 1, -4094, -4094, 0, 4096));
		// extreme candidates against an extreme moving rect
		add_row(word(MODE_MOVING, POS_MIN, POS_MIN, LEN_MAX, LEN_MAX, 1'b0), 1'b0, '0);
		add_row(word(MODE_CANDIDATE, POS_MAX, POS_MAX, LEN_MAX, LEN_MAX, 1'b0), 1'b0, '0);
		add_row(word(MODE_CANDIDATE, POS_MIN, POS_MIN, LEN_MAX, 0, 1'b1), 1'b0, '0);

		foreach (script[i])
			send_word(script[i].word, script[i].typed, script[i].want);

		// Random phases, one threshold each. The write lands between phases,
		// often with a search still open, so it only counts from the next
		// moving word.
		for (int phase = 0; words_taken < ITEM_TARGET; phase++) begin
			drain_results();
			case (phase % 6)
				0:       thr = THR_MAX;
				1:       thr = '0;
				2:       thr = THR_RESET;
				3:       thr = {1'($urandom), $urandom};
				4:       thr = THR_W'($urandom_range(1, 1 << 16));
				default: thr = THR_W'($urandom_range(1 << 16, 1 << 24));
			endcase
			// upper data bits are junk; only the register width sticks
			apb_write(THR_ADDR, {31'($urandom), thr});
			snap_limit = thr;
			// a write to the unused slot must leave the threshold alone
			if (phase == 1)
				apb_write(UNMAPPED_ADDR, {$urandom, $urandom});
			apb_read_check(THR_ADDR, DATA_W'(snap_limit));
			src_idle  = ($urandom_range(0, 3) != 0);
			snk_idle  = ($urandom_range(0, 3) != 0);
			phase_end = words_taken + PHASE_WORDS;
			while (words_taken < phase_end)
				run_search();
		end

		drain_results();
		if (snap_errors == 0)
			$display("rect_edge_snap_search test passed");
		else
			$display("rect_edge_snap_search test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random ready gaps, check each word taken
	// ------------------------------------------------------------------------
	initial begin
		int gap;
		snap_result_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = snk_idle ? $urandom_range(0, 10) : 0;
			if (gap > 0 || hold_results) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_results) @(posedge clk);
			end
			out_ready <= 1'b1;
			// outputs are stable mid-cycle; the word moves at the next edge
			do @(negedge clk); while (!out_valid);
			if (awaited_snaps.size() == 0) begin
				snap_errors++;
				if (snap_errors <= MAX_REPORTS)
					$display("%0t mismatch: result word with none expected", $realtime);
			end else begin
				want = awaited_snaps.pop_front();
				flag_mismatch("found_x", 64'(want.found_x), 64'(found_x));
				flag_mismatch("offset_x", 64'(want.offset_x), 64'(offset_x));
				flag_mismatch("guide_x_position", 64'(want.guide_x),
					64'(guide_x_position));
				flag_mismatch("span_top", 64'(want.span_top), 64'(span_top));
				flag_mismatch("span_bottom", 64'(want.span_bottom), 64'(span_bottom));
				flag_mismatch("found_y", 64'(want.found_y), 64'(found_y));
				flag_mismatch("offset_y", 64'(want.offset_y), 64'(offset_y));
				flag_mismatch("guide_y_position", 64'(want.guide_y),
					64'(guide_y_position));
				flag_mismatch("span_left", 64'(want.span_left), 64'(span_left));
				flag_mismatch("span_right", 64'(want.span_right), 64'(span_right));
			end
			@(posedge clk);
		end
	end

	// Long hold-off on the result side, counted here; the sender keeps
	// offering so a last word backs up and in_ready drops.
	initial begin
		wait (words_taken >= HOLD_AT);
		@(negedge clk);
		hold_results = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_results = 1'b0;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("rect_edge_snap_search test failed");
		$finish;
	end

endmodule
